// ===== hdl/crosstalk_charge_share_injector_core_defines.svh =====
// Assertion macros for the crosstalk charge-share injector core.
// Included by every RTL file that carries concurrent assertions.
// No dependencies.
`ifndef CROSSTALK_CHARGE_SHARE_INJECTOR_CORE_DEFINES_SVH
`define CROSSTALK_CHARGE_SHARE_INJECTOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Checked property with synchronous active-low reset disable
`define CCSI_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("ccsi assertion failed");
// Checked property that also holds during reset
`define CCSI_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("ccsi assertion failed");
`else
`define CCSI_ASSERT(label, clk, rstn, prop)
`define CCSI_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== hdl/ccsi_pkg.sv =====
// Shared types, widths and constants of the crosstalk charge-share injector.
// Used by all modules of the core; depends on nothing.
package ccsi_pkg;

    // Default geometry
    localparam int CHANNELS_PER_PLANE_DEF = 256;
    localparam int PLANE_COUNT_DEF        = 9;

    // Field widths
    localparam int RAW_W      = 12;
    localparam int PED_W      = 17;
    localparam int PLANE_W    = 4;
    localparam int CHAN_W     = 8;
    localparam int FRAC_W     = 17;
    localparam int FLOOR_W    = 16;
    localparam int SAMPLE_W   = 12;
    localparam int SHARE_W    = 32;
    localparam int CHAN_CMP_W = 11;   // holds the largest channel count

    // Stream packing
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 16;
    localparam int RAW_LSB   = 0;
    localparam int PED_LSB   = 12;
    localparam int PLANE_LSB = 29;
    localparam int CHAN_LSB  = 33;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIP_FRAC  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_FRAC    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIP_FLOOR = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_FLOOR   = 2'd3;

    // Reset values and clamp limits
    localparam logic [FLOOR_W-1:0]  STRIP_FLOOR_RST = 16'd592;   // 37.0 in Q.4
    localparam logic [FLOOR_W-1:0]  PAD_FLOOR_RST   = 16'd8000;  // 500.0 in Q.4
    localparam logic [SAMPLE_W-1:0] STRIP_MAX       = 12'd255;
    localparam logic [SAMPLE_W-1:0] PAD_MAX         = 12'd4095;

    // Item held between the store read and the share stage
    typedef struct packed {
        logic [RAW_W-1:0]        raw;
        logic signed [PED_W-1:0] ped;
        logic                    pad;
        logic                    replaced;
        logic                    start;
        logic [FRAC_W-1:0]       frac;
    } ccsi_item_t;

endpackage

// ===== hdl/crosstalk_charge_share_injector_core.sv =====
// Top level of the crosstalk charge-share injector: configuration registers,
// item decode, store access and the pipeline register ahead of the share stage.
// Uses ccsi_pkg, ccsi_ped_store, ccsi_share_stage and the assertion macros.
//
// Usage:
//   Input items arrive on s_tvalid/s_tready/s_tdata/s_tuser, one detector
//   channel sample each, in readout order. Results leave on m_tvalid/m_tready/
//   m_tdata/m_tuser, one per input item, in the same order.
//   Configuration registers are written on cfg_valid/cfg_ready/cfg_index/
//   cfg_data; cfg_ready is always high. Write them only while the block is idle.
// Pipeline and throughput:
//   An accepted item is registered in stage 1, then in the output register
//   that drives m_tvalid. One item per cycle is sustained while m_tready is
//   high: the pedestal store takes a single read or write per item on its one
//   port; the carried share loop (add, round, multiply, saturate) closes on cs_reg.
// Reset:
//   aresetn (synchronous, active low) clears the pipeline, the carried share
//   and the registers, then a sweep zeroes all PLANE_COUNT * CHANNELS_PER_PLANE
//   entries of the pedestal store (2304 at defaults); s_tready stays low during
//   that sweep.
// Stall:
//   When m_tready is low the result waits in the output register; one more
//   item may still be accepted into the stage ahead of it, then s_tready drops.
`include "crosstalk_charge_share_injector_core_defines.svh"

module crosstalk_charge_share_injector_core #(
    parameter int CHANNELS_PER_PLANE = ccsi_pkg::CHANNELS_PER_PLANE_DEF,
    parameter int PLANE_COUNT        = ccsi_pkg::PLANE_COUNT_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Input items
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [11:0] raw_sample, [28:12] pedestal_mean, [32:29] plane, [40:33] channel
    input  logic [ccsi_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic [0:0]                         s_tuser,   // [0] plane_start
    // Result items
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [ccsi_pkg::M_TDATA_W-1:0]     m_tdata,   // [11:0] shared_sample
    output logic [0:0]                         m_tuser,   // [0] pedestal_replaced
    // Configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ccsi_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ccsi_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int DEPTH  = PLANE_COUNT * CHANNELS_PER_PLANE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [ccsi_pkg::PLANE_W:0]      PLANES_L = (ccsi_pkg::PLANE_W+1)'(PLANE_COUNT);
    localparam logic [ccsi_pkg::PLANE_W-1:0]    PAD_PLANE = ccsi_pkg::PLANE_W'(PLANE_COUNT - 1);
    localparam logic [ccsi_pkg::CHAN_CMP_W-1:0] CHANS_L =
        ccsi_pkg::CHAN_CMP_W'(CHANNELS_PER_PLANE);

    // Configuration registers
    logic [ccsi_pkg::FRAC_W-1:0]  strip_frac_reg;
    logic [ccsi_pkg::FRAC_W-1:0]  pad_frac_reg;
    logic [ccsi_pkg::FLOOR_W-1:0] strip_floor_reg;
    logic [ccsi_pkg::FLOOR_W-1:0] pad_floor_reg;

    // Decode
    logic [ccsi_pkg::RAW_W-1:0]        in_raw;
    logic signed [ccsi_pkg::PED_W-1:0] in_ped;
    logic [ccsi_pkg::PLANE_W-1:0]      in_plane;
    logic [ccsi_pkg::CHAN_W-1:0]       in_chan;
    logic                              in_pad;
    logic                              in_range;
    logic [ccsi_pkg::FLOOR_W-1:0]      floor_sel;
    logic                              ped_low;
    logic [ADDR_W-1:0]                 idx;
    ccsi_pkg::ccsi_item_t              item_next;

    // Handshake and stage 1
    logic                              accept;
    logic                              st1_valid_reg;
    ccsi_pkg::ccsi_item_t              st1_item_reg;
    logic                              st1_ready;
    logic                              out_ready;
    logic                              store_busy;
    logic                              rd_en;
    logic                              wr_en;
    logic signed [ccsi_pkg::PED_W-1:0] rd_data;

    // Register writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strip_frac_reg  <= '0;
            pad_frac_reg    <= '0;
            strip_floor_reg <= ccsi_pkg::STRIP_FLOOR_RST;
            pad_floor_reg   <= ccsi_pkg::PAD_FLOOR_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                ccsi_pkg::CFG_STRIP_FRAC: begin
                    strip_frac_reg <= cfg_data;
                end
                ccsi_pkg::CFG_PAD_FRAC: begin
                    pad_frac_reg <= cfg_data;
                end
                ccsi_pkg::CFG_STRIP_FLOOR: begin
                    strip_floor_reg <= cfg_data[ccsi_pkg::FLOOR_W-1:0];
                end
                ccsi_pkg::CFG_PAD_FLOOR: begin
                    pad_floor_reg <= cfg_data[ccsi_pkg::FLOOR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Unpack the item and decide between store read and store update
    always_comb begin
        in_raw    = s_tdata[ccsi_pkg::RAW_LSB +: ccsi_pkg::RAW_W];
        in_ped    = signed'(s_tdata[ccsi_pkg::PED_LSB +: ccsi_pkg::PED_W]);
        in_plane  = s_tdata[ccsi_pkg::PLANE_LSB +: ccsi_pkg::PLANE_W];
        in_chan   = s_tdata[ccsi_pkg::CHAN_LSB +: ccsi_pkg::CHAN_W];
        in_pad    = (in_plane == PAD_PLANE);
        in_range  = ({1'b0, in_plane} < PLANES_L) &&
                    ({{(ccsi_pkg::CHAN_CMP_W-ccsi_pkg::CHAN_W){1'b0}}, in_chan} < CHANS_L);
        floor_sel = in_pad ? pad_floor_reg : strip_floor_reg;
        ped_low   = in_ped < signed'({1'b0, floor_sel});
        idx       = ADDR_W'(in_plane) * ADDR_W'(CHANNELS_PER_PLANE) + ADDR_W'(in_chan);

        item_next.raw      = in_raw;
        item_next.ped      = in_ped;
        item_next.pad      = in_pad;
        item_next.replaced = in_range && ped_low;
        item_next.start    = s_tuser[0];
        item_next.frac     = in_pad ? pad_frac_reg : strip_frac_reg;
    end

    assign st1_ready = !st1_valid_reg || out_ready;
    assign s_tready  = st1_ready && !store_busy;
    assign accept    = s_tvalid && s_tready;
    assign rd_en     = accept && in_range && ped_low;
    assign wr_en     = accept && in_range && !ped_low;

    // Stage 1 waits for the registered store read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (st1_ready) begin
            st1_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st1_item_reg <= item_next;
        end
    end

    ccsi_ped_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (rd_en),
        .wr_en   (wr_en),
        .addr    (idx),
        .wr_data (in_ped),
        .rd_data (rd_data),
        .busy    (store_busy)
    );

    ccsi_share_stage u_share (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .st1_valid (st1_valid_reg),
        .st1_item  (st1_item_reg),
        .rd_data   (rd_data),
        .out_ready (out_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // No item is taken while the store is being cleared
    `CCSI_ASSERT(a_no_accept_in_clear, aclk, aresetn, store_busy |-> !s_tready)
    // An accepted item always lands in stage 1
    `CCSI_ASSERT(a_accept_to_st1, aclk, aresetn, accept |=> st1_valid_reg)

endmodule

// ===== hdl/ccsi_ped_store.sv =====
// Pedestal store: one synchronous RAM, one access per cycle, registered read.
// Runs a zero-fill sweep after reset. Uses ccsi_pkg and the assertion macros.
`include "crosstalk_charge_share_injector_core_defines.svh"

module ccsi_ped_store #(
    parameter int DEPTH  = ccsi_pkg::CHANNELS_PER_PLANE_DEF * ccsi_pkg::PLANE_COUNT_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              rd_en,
    input  logic                              wr_en,
    input  logic [ADDR_W-1:0]                 addr,
    input  logic signed [ccsi_pkg::PED_W-1:0] wr_data,
    output logic signed [ccsi_pkg::PED_W-1:0] rd_data,
    output logic                              busy
);

    logic signed [ccsi_pkg::PED_W-1:0] mem [DEPTH];
    logic signed [ccsi_pkg::PED_W-1:0] rd_data_reg;
    logic                              clr_busy_reg;
    logic [ADDR_W-1:0]                 clr_addr_reg;
    logic                              mem_we;
    logic [ADDR_W-1:0]                 mem_waddr;
    logic signed [ccsi_pkg::PED_W-1:0] mem_wdata;

    // Clearing sweep, one entry per cycle after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            if (clr_addr_reg == ADDR_W'(DEPTH - 1)) begin
                clr_busy_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
        end
    end

    // Write port is shared between the sweep and item writes
    assign mem_we    = clr_busy_reg | wr_en;
    assign mem_waddr = clr_busy_reg ? clr_addr_reg : addr;
    assign mem_wdata = clr_busy_reg ? '0 : wr_data;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_busy_reg;

    // An item either reads or writes its entry, never both
    `CCSI_ASSERT(a_store_rw_excl, aclk, aresetn, !(rd_en && wr_en))
    // No item access while the sweep owns the port
    `CCSI_ASSERT(a_store_no_item_in_clear, aclk, aresetn, clr_busy_reg |-> !(rd_en || wr_en))

endmodule

// ===== hdl/ccsi_share_stage.sv =====
// Share stage: picks the pedestal, adds the carried share, rounds, clamps and
// computes the next carried share; holds the output register. Uses ccsi_pkg.
`include "crosstalk_charge_share_injector_core_defines.svh"

module ccsi_share_stage (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              st1_valid,
    input  ccsi_pkg::ccsi_item_t              st1_item,
    input  logic signed [ccsi_pkg::PED_W-1:0] rd_data,
    output logic                              out_ready,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ccsi_pkg::M_TDATA_W-1:0]    m_tdata,  // [11:0] shared_sample
    output logic [0:0]                        m_tuser   // [0] pedestal_replaced
);

    localparam int SUM_W  = 34;
    localparam int SIG_W  = 35;
    localparam int PROD_W = SIG_W + ccsi_pkg::FRAC_W + 1;
    localparam int SH_W   = PROD_W - 16;

    logic signed [ccsi_pkg::SHARE_W-1:0]  cs_reg;
    logic signed [ccsi_pkg::SHARE_W-1:0]  cs_next;
    logic                                 m_valid_reg;
    logic [ccsi_pkg::SAMPLE_W-1:0]        sample_reg;
    logic                                 repl_reg;

    logic signed [ccsi_pkg::PED_W-1:0]    ped_eff;
    logic signed [ccsi_pkg::SHARE_W-1:0]  cs_eff;
    logic signed [SUM_W-1:0]              sum;
    logic signed [SUM_W-1:0]              sum_rnd;
    logic [SUM_W-9:0]                     res_full;
    logic [ccsi_pkg::SAMPLE_W-1:0]        maxv;
    logic [ccsi_pkg::SAMPLE_W-1:0]        res;
    logic signed [SIG_W-1:0]              ped16;
    logic signed [SIG_W-1:0]              signal;
    logic signed [PROD_W-1:0]             prod;
    logic signed [PROD_W-1:0]             prod_rnd;
    logic signed [SH_W-1:0]               sh;
    logic                                 advance;

    // Sample plus carried share, rounded half up and clamped
    always_comb begin
        ped_eff  = st1_item.replaced ? rd_data : st1_item.ped;
        cs_eff   = st1_item.start ? '0 : cs_reg;
        sum      = SUM_W'(signed'({1'b0, st1_item.raw, 8'h00})) + SUM_W'(cs_eff);
        sum_rnd  = sum + SUM_W'(128);
        res_full = sum_rnd[SUM_W-1:8];
        maxv     = st1_item.pad ? ccsi_pkg::PAD_MAX : ccsi_pkg::STRIP_MAX;
        if (sum[SUM_W-1]) begin
            res = '0;
        end else if (res_full > (SUM_W-8)'(maxv)) begin
            res = maxv;
        end else begin
            res = res_full[ccsi_pkg::SAMPLE_W-1:0];
        end
    end

    // Next carried share: fraction times signal, Q.24 back to Q.8, saturated
    always_comb begin
        ped16    = signed'({{(SIG_W-ccsi_pkg::PED_W-4){ped_eff[ccsi_pkg::PED_W-1]}},
                            ped_eff, 4'h0});
        signal   = st1_item.pad ? (SIG_W'(signed'({1'b0, res, 8'h00})) - ped16)
                                : (SIG_W'(sum) - ped16);
        prod     = PROD_W'(signal) * PROD_W'(signed'({1'b0, st1_item.frac}));
        prod_rnd = prod + PROD_W'(32768);
        sh       = prod_rnd[PROD_W-1:16];
        if (sh[SH_W-1:ccsi_pkg::SHARE_W-1] == '0 ||
            sh[SH_W-1:ccsi_pkg::SHARE_W-1] == '1) begin
            cs_next = sh[ccsi_pkg::SHARE_W-1:0];
        end else if (sh[SH_W-1]) begin
            cs_next = {1'b1, {(ccsi_pkg::SHARE_W-1){1'b0}}};
        end else begin
            cs_next = {1'b0, {(ccsi_pkg::SHARE_W-1){1'b1}}};
        end
    end

    assign out_ready = !m_valid_reg || m_tready;
    assign advance   = st1_valid && out_ready;

    // Carried share and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cs_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                cs_reg <= cs_next;
            end
            if (out_ready) begin
                m_valid_reg <= st1_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            sample_reg <= res;
            repl_reg   <= st1_item.replaced;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(ccsi_pkg::M_TDATA_W-ccsi_pkg::SAMPLE_W){1'b0}}, sample_reg};
    assign m_tuser  = repl_reg;

    // A strip-plane result never exceeds the strip clamp
    `CCSI_ASSERT(a_strip_clamp, aclk, aresetn,
        (advance && !st1_item.pad) |=> (sample_reg <= ccsi_pkg::STRIP_MAX))

endmodule

// ===== tb/ccsi_share_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the crosstalk charge-share injector: watches the item, result and
// register-write channels, predicts each result and compares it. Depends on ccsi_pkg.
module ccsi_share_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [ccsi_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [0:0]                       s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [ccsi_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic [0:0]                       m_tuser,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [ccsi_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ccsi_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                               mismatch_count,
    output int                               pending_results,
    output int                               results_checked
);

    localparam int CHANNELS    = ccsi_pkg::CHANNELS_PER_PLANE_DEF;
    localparam int PLANES      = ccsi_pkg::PLANE_COUNT_DEF;
    localparam int STORE_DEPTH = PLANES * CHANNELS;
    localparam int SAMPLE_W    = ccsi_pkg::SAMPLE_W;

    typedef struct {
        logic [SAMPLE_W-1:0] sample;
        logic                replaced;
    } shared_out_t;

    // Predictor state and register copies
    logic [ccsi_pkg::FRAC_W-1:0]  strip_frac;
    logic [ccsi_pkg::FRAC_W-1:0]  pad_frac;
    logic [ccsi_pkg::FLOOR_W-1:0] strip_floor;
    logic [ccsi_pkg::FLOOR_W-1:0] pad_floor;
    int                 share_carry;            // Q.8
    int                 ped_store [STORE_DEPTH]; // Q.4
    shared_out_t        expected_samples [$];
    int                 errors;
    int                 checked;
    shared_out_t        want;

    // Predict one channel sample and advance the carried share
    function automatic shared_out_t inject_share(
        input logic [ccsi_pkg::RAW_W-1:0]        raw,
        input logic signed [ccsi_pkg::PED_W-1:0] ped_in,
        input logic [ccsi_pkg::PLANE_W-1:0]      plane,
        input logic [ccsi_pkg::CHAN_W-1:0]       chan,
        input logic                              start
    );
        shared_out_t r;
        bit          pad;
        longint      ped, sum, res, maxv, signal, prod, frac, floorv;
        int          idx;
        pad    = (plane == PLANES - 1);
        maxv   = pad ? longint'(ccsi_pkg::PAD_MAX) : longint'(ccsi_pkg::STRIP_MAX);
        frac   = pad ? longint'(pad_frac) : longint'(strip_frac);
        floorv = pad ? longint'(pad_floor) : longint'(strip_floor);
        ped    = ped_in;
        r.replaced = 1'b0;
        if (start)
            share_carry = 0;
        // Store lookup only for tags on the map
        if (plane < PLANES && chan < CHANNELS) begin
            idx = int'(plane) * CHANNELS + int'(chan);
            if (ped < floorv) begin
                ped = ped_store[idx];
                r.replaced = 1'b1;
            end else begin
                ped_store[idx] = int'(ped);
            end
        end
        // Add share, round half up, clamp
        sum = longint'(raw) * 256 + longint'(share_carry);
        if (sum < 0) begin
            res = 0;
        end else begin
            res = (sum + 128) >>> 8;
            if (res > maxv)
                res = maxv;
        end
        // Next share: Q.8 signal times Q1.16 fraction, back to Q.8
        signal = pad ? (res * 256 - ped * 16) : (sum - ped * 16);
        prod   = (signal * frac + 32768) >>> 16;
        if (prod > 64'sd2147483647)
            share_carry = 32'sh7fffffff;
        else if (prod < -64'sd2147483648)
            share_carry = 32'sh80000000;
        else
            share_carry = int'(prod);
        r.sample = res[SAMPLE_W-1:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            strip_frac  = '0;
            pad_frac    = '0;
            strip_floor = ccsi_pkg::STRIP_FLOOR_RST;
            pad_floor   = ccsi_pkg::PAD_FLOOR_RST;
            share_carry = 0;
            for (int i = 0; i < STORE_DEPTH; i++)
                ped_store[i] = 0;
            expected_samples.delete();
        end else begin
            // Result side
            if (m_tvalid && m_tready) begin
                checked++;
                if (expected_samples.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result item sample %0d replaced %0b",
                             $time, m_tdata[SAMPLE_W-1:0], m_tuser[0]);
                end else begin
                    want = expected_samples.pop_front();
                    if (m_tdata[SAMPLE_W-1:0] !== want.sample) begin
                        errors++;
                        $display("%0t: shared_sample expected %0d got %0d",
                                 $time, want.sample, m_tdata[SAMPLE_W-1:0]);
                    end
                    if (m_tuser[0] !== want.replaced) begin
                        errors++;
                        $display("%0t: pedestal_replaced expected %0b got %0b",
                                 $time, want.replaced, m_tuser[0]);
                    end
                end
            end
            // Register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    ccsi_pkg::CFG_STRIP_FRAC:
                        strip_frac  = cfg_data[ccsi_pkg::FRAC_W-1:0];
                    ccsi_pkg::CFG_PAD_FRAC:
                        pad_frac    = cfg_data[ccsi_pkg::FRAC_W-1:0];
                    ccsi_pkg::CFG_STRIP_FLOOR:
                        strip_floor = cfg_data[ccsi_pkg::FLOOR_W-1:0];
                    ccsi_pkg::CFG_PAD_FLOOR:
                        pad_floor   = cfg_data[ccsi_pkg::FLOOR_W-1:0];
                    default: ;
                endcase
            end
            // Input side
            if (s_tvalid && s_tready)
                expected_samples.push_back(inject_share(
                    s_tdata[ccsi_pkg::RAW_LSB +: ccsi_pkg::RAW_W],
                    s_tdata[ccsi_pkg::PED_LSB +: ccsi_pkg::PED_W],
                    s_tdata[ccsi_pkg::PLANE_LSB +: ccsi_pkg::PLANE_W],
                    s_tdata[ccsi_pkg::CHAN_LSB +: ccsi_pkg::CHAN_W],
                    s_tuser[0]));
        end
        pending_results <= expected_samples.size();
        mismatch_count  <= errors;
        results_checked <= checked;
    end

endmodule

// ===== tb/crosstalk_charge_share_injector_core_tb.sv =====
`timescale 1ns / 1ps
// Top of the charge-share injector testbench: clock, reset, register settings and
// item stimulus with random gaps and stalls; verdict from ccsi_share_checker.
module crosstalk_charge_share_injector_core_tb;

    localparam int PLANES      = ccsi_pkg::PLANE_COUNT_DEF;
    localparam int PLANE_W     = ccsi_pkg::PLANE_W;
    localparam int CHAN_W      = ccsi_pkg::CHAN_W;
    localparam int RAW_W       = ccsi_pkg::RAW_W;
    localparam int PED_W       = ccsi_pkg::PED_W;
    localparam int CFG_IDX_W   = ccsi_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W  = ccsi_pkg::CFG_DATA_W;
    localparam int S_TDATA_W   = ccsi_pkg::S_TDATA_W;
    localparam int M_TDATA_W   = ccsi_pkg::M_TDATA_W;
    localparam int CHAN_LSB    = ccsi_pkg::CHAN_LSB;
    localparam logic [PLANE_W-1:0] PAD_PLANE = PLANE_W'(PLANES - 1);
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 212;
    localparam int FRAC_MAX    = 131071;
    localparam int FLOOR_MAX   = 65535;
    localparam int STRIP_FLOOR_DEF = int'(ccsi_pkg::STRIP_FLOOR_RST);
    localparam int PAD_FLOOR_DEF   = int'(ccsi_pkg::PAD_FLOOR_RST);

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [0:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [0:0]            m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int  mismatch_count, pending_results, results_checked;
    logic calm = 1'b0;     // no gaps, no stalls
    int  items_sent = 0, pad_items = 0, offmap_items = 0, settings_used = 0;
    int  cur_strip_floor, cur_pad_floor;

    crosstalk_charge_share_injector_core dut (.*);

    ccsi_share_checker checker_i (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver stalls
    always @(posedge aclk)
        m_tready <= calm || ($urandom_range(99) >= 12);

    // Run limit
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("crosstalk_charge_share_injector_core: mismatch");
        $finish;
    end

    task automatic send_item(input logic [RAW_W-1:0] raw, input logic signed [PED_W-1:0] ped,
                             input logic [PLANE_W-1:0] plane, input logic [CHAN_W-1:0] chan,
                             input logic start);
        int gap;
        gap = 0;
        if (!calm)
            while ($urandom_range(99) < 12 && gap < 8) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-CHAN_LSB-CHAN_W){1'b0}}, chan, plane, ped, raw};
        s_tuser  <= start;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (plane == PAD_PLANE) pad_items++;
        if (plane > PAD_PLANE) offmap_items++;
    endtask

    // Hold the sender until every result is back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic apply_setting(input int strip_frac, input int pad_frac,
                                 input int strip_floor, input int pad_floor);
        drain();
        write_reg(ccsi_pkg::CFG_STRIP_FRAC, strip_frac);
        write_reg(ccsi_pkg::CFG_PAD_FRAC, pad_frac);
        write_reg(ccsi_pkg::CFG_STRIP_FLOOR, strip_floor);
        write_reg(ccsi_pkg::CFG_PAD_FLOOR, pad_floor);
        cfg_valid <= 1'b0;
        cur_strip_floor = strip_floor;
        cur_pad_floor   = pad_floor;
        settings_used++;
    endtask

    function automatic int pick_fraction();
        int r;
        r = $urandom_range(99);
        if (r < 15) return 0;
        if (r < 25) return FRAC_MAX;
        return int'($urandom_range(30000));
    endfunction

    function automatic int pick_floor(input int lo, input int hi);
        int r;
        r = $urandom_range(99);
        if (r < 10) return 0;
        if (r < 20) return FLOOR_MAX;
        return int'($urandom_range(hi, lo));
    endfunction

    // Pedestal often near the floor, some negative, some anywhere and some above it
    function automatic logic signed [PED_W-1:0] pick_pedestal(input int floorv);
        int r, v;
        r = $urandom_range(99);
        if (r < 45)
            v = floorv + int'($urandom_range(128)) - 64;
        else if (r < 60)
            v = -int'($urandom_range(65536, 1));
        else if (r < 80)
            v = int'($urandom_range(131071)) - 65536;
        else
            v = floorv + int'($urandom_range(4000));
        if (v > 65535) v = 65535;
        if (v < -65536) v = -65536;
        return v[PED_W-1:0];
    endfunction

    initial begin
        int run_plane, run_chan, run_left;
        logic first;
        logic [PLANE_W-1:0] plane;
        logic [CHAN_W-1:0]  chan;
        logic [RAW_W-1:0]   raw;
        logic               start;
        run_left = 0;
        first    = 1'b0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        // Wait out the store clearing sweep
        do @(posedge aclk); while (!s_tready);

        // Directed part: half share on strips, quarter on pad, reset floors
        apply_setting(32768, 16384, STRIP_FLOOR_DEF, PAD_FLOOR_DEF);
        send_item(12'd0,    17'sd1000,   4'd0, 8'd0,   1'b1);  // store written
        send_item(12'd4095, 17'sd592,    4'd0, 8'd1,   1'b0);  // floor exactly, clamp 255
        send_item(12'd100,  17'sd591,    4'd0, 8'd2,   1'b0);  // below floor, stored zero
        send_item(12'd50,   -17'sd65536, 4'd0, 8'd0,   1'b0);  // negative pedestal
        send_item(12'd200,  17'sd65535,  4'd0, 8'd1,   1'b0);
        send_item(12'd4095, 17'sd8000,   PAD_PLANE, 8'd0, 1'b1);
        send_item(12'd4095, 17'sd65535,  PAD_PLANE, 8'd1, 1'b0);
        send_item(12'd0,    17'sd7999,   PAD_PLANE, 8'd255, 1'b0);
        send_item(12'd1,    -17'sd1,     PAD_PLANE, 8'd0, 1'b0);
        send_item(12'd300,  -17'sd100,   4'd9, 8'd3,   1'b0);  // plane off the map
        send_item(12'd4095, 17'sd65535,  4'd15, 8'd255, 1'b1);
        send_item(12'd128,  17'sd592,    4'd3, 8'd0,   1'b0);  // plane change, no start
        send_item(12'd0,    17'sd0,      4'd7, 8'd255, 1'b1);
        send_item(12'd0,    17'sd65535,  4'd1, 8'd0,   1'b1);  // big negative share
        send_item(12'd0,    17'sd600,    4'd1, 8'd1,   1'b0);  // negative sum
        send_item(12'd2,    17'sd600,    4'd1, 8'd2,   1'b0);
        send_item(12'd255,  17'sd4000,   4'd2, 8'd170, 1'b1);
        send_item(12'd2730, 17'sd21845,  PAD_PLANE, 8'd85, 1'b0);

        // Random part, one register setting per phase
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: apply_setting(FRAC_MAX, FRAC_MAX, 0, 0);
                1: apply_setting(0, 0, FLOOR_MAX, FLOOR_MAX);
                PHASES - 1: apply_setting(16384, 8192, STRIP_FLOOR_DEF, PAD_FLOOR_DEF);
                default: apply_setting(pick_fraction(), pick_fraction(),
                                       pick_floor(200, 1200), pick_floor(2000, 12000));
            endcase
            calm <= (ph == 4);
            run_left = 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (run_left == 0) begin
                    run_plane = int'($urandom_range(PAD_PLANE));
                    run_chan  = ($urandom_range(3) == 0) ? int'($urandom_range(255)) : 0;
                    run_left  = int'($urandom_range(40, 4));
                    first     = 1'b1;
                end
                if ($urandom_range(99) < 15) begin
                    // Stray item: any tag, any start
                    plane = PLANE_W'($urandom_range(15));
                    chan  = CHAN_W'($urandom_range(255));
                    start = 1'($urandom_range(1));
                end else begin
                    plane = PLANE_W'(run_plane);
                    chan  = CHAN_W'(run_chan);
                    start = first;
                    first = 1'b0;
                    run_chan++;
                    run_left--;
                    if (run_chan > 255) run_left = 0;
                end
                if (plane == PAD_PLANE || $urandom_range(3) == 0)
                    raw = RAW_W'($urandom_range(4095));
                else
                    raw = RAW_W'($urandom_range(300));
                send_item(raw, pick_pedestal(plane == PAD_PLANE ? cur_pad_floor
                                                                : cur_strip_floor),
                          plane, chan, start);
            end
        end

        drain();
        repeat (8) @(posedge aclk);
        $display("run covered %0d items (%0d pad plane, %0d off the map) in %0d settings",
                 items_sent, pad_items, offmap_items, settings_used);
        $display("%0d result items checked, %0d mismatches", results_checked, mismatch_count);
        if (mismatch_count == 0 && pending_results == 0)
            $display("crosstalk_charge_share_injector_core: match");
        else
            $display("crosstalk_charge_share_injector_core: mismatch");
        $finish;
    end

endmodule
